>>> hw/rtl/urpm_pkg.sv
// ----------------------------------------------------------------------------
// urpm_pkg: shared types and constants of the ultrasonic ranger pulse model
// Counter widths, echo-length scaling constants and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package urpm_pkg;

   // timing constants, in microseconds
   localparam int MIN_TRIG_US = 10;
   localparam int DELAY_US    = 200;

   // field and counter widths
   localparam int TPU_W   = 8;
   localparam int DIST_W  = 12;
   localparam int PULSE_W = 16;
   localparam int DELAY_W = 16;
   localparam int ECHO_W  = 24;

   // echo length: ((dist*ECHO_NUM + ECHO_RND) * tpu) >> ECHO_SHIFT (Q12 of 2/0.344)
   localparam int ECHO_NUM   = 23814;
   localparam int ECHO_RND   = 2048;
   localparam int ECHO_SHIFT = 12;

   localparam int TPU_MAX     = (1 << TPU_W) - 1;
   localparam int DIST_MAX    = (1 << DIST_W) - 1;
   localparam int P1_W        = $clog2(DIST_MAX * ECHO_NUM + ECHO_RND + 1);
   localparam int P2_W        = P1_W + TPU_W;
   localparam int NEED_W      = $clog2(MIN_TRIG_US * TPU_MAX + 1);
   localparam int DLY_FULL_W  = $clog2(DELAY_US * TPU_MAX + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_LOAD
   } urpm_state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // take trigger item: edge handling, first product
      logic step;       // counter step without a reload
      logic mul;        // second product (scale by ticks per us)
      logic load_step;  // reload counters, then one counter step
   } urpm_cmd_type;

   // datapath -> controller / top
   typedef struct packed {
      logic load;        // current trigger item ends a valid pulse
      logic measuring;
      logic delay_zero;
      logic echo_high;
   } urpm_status_type;

endpackage

>>> hw/rtl/urpm_ctrl.sv
// ----------------------------------------------------------------------------
// urpm_ctrl: sequencer of the ultrasonic ranger pulse model
// Accepts items, routes a reloading item through the two multiplier steps
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module urpm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  urpm_pkg::urpm_status_type status,
   output urpm_pkg::urpm_cmd_type    cmd
);

   urpm_pkg::urpm_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic accept;
   logic rsp_write;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         urpm_pkg::ST_IDLE: begin
            if (accept && status.load) state_in = urpm_pkg::ST_MUL;
         end
         urpm_pkg::ST_MUL: begin
            state_in = urpm_pkg::ST_LOAD;
         end
         urpm_pkg::ST_LOAD: begin
            if (out_free) state_in = urpm_pkg::ST_IDLE;
         end
         default: begin
            state_in = urpm_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      rsp_write = 1'b0;
      unique case (state_ff)
         urpm_pkg::ST_IDLE: begin
            req_ready   = out_free;
            cmd.capture = accept;
            cmd.step    = accept && !status.load;
            rsp_write   = accept && !status.load;
         end
         urpm_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         urpm_pkg::ST_LOAD: begin
            cmd.load_step = out_free;
            rsp_write     = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= urpm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/urpm_dp.sv
// ----------------------------------------------------------------------------
// urpm_dp: datapath of the ultrasonic ranger pulse model
// Rate register, pulse-width measurement, echo-length multiplier steps and
// the delay and echo counters.
// ----------------------------------------------------------------------------
module urpm_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [urpm_pkg::TPU_W-1:0]        csr_wr_data,
   input  logic                              req_trig_level,
   input  logic [urpm_pkg::DIST_W-1:0]       req_distance_mm,
   input  urpm_pkg::urpm_cmd_type            cmd,
   output urpm_pkg::urpm_status_type         status,
   output logic                              echo_level
);

   logic [urpm_pkg::TPU_W-1:0]   tpu_ff, tpu_in;
   logic                         prev_trig_ff, prev_trig_in;
   logic [urpm_pkg::PULSE_W-1:0] pulse_ff, pulse_in;
   logic [urpm_pkg::DELAY_W-1:0] delay_ff, delay_in;
   logic [urpm_pkg::ECHO_W-1:0]  echo_cnt_ff, echo_cnt_in;
   logic                         measuring_ff, measuring_in;
   logic                         echo_ff, echo_in;
   logic [urpm_pkg::P1_W-1:0]    p1_ff, p1_in;
   logic [urpm_pkg::ECHO_W-1:0]  elen_ff, elen_in;

   logic [urpm_pkg::TPU_W-1:0]      rate;
   logic [urpm_pkg::NEED_W-1:0]     need;
   logic [urpm_pkg::PULSE_W-1:0]    pulse_inc;
   logic [urpm_pkg::DLY_FULL_W-1:0] dly_full;
   logic [urpm_pkg::DELAY_W-1:0]    dly_sat;
   logic [urpm_pkg::P2_W-1:0]       p2;
   logic [urpm_pkg::ECHO_W-1:0]     elen_clamp;
   logic [urpm_pkg::ECHO_W-1:0]     echo_dec;

   // zero rate behaves as one tick per us
   assign rate = (tpu_ff == '0) ? urpm_pkg::TPU_W'(1) : tpu_ff;
   assign need = urpm_pkg::NEED_W'(rate) * urpm_pkg::NEED_W'(urpm_pkg::MIN_TRIG_US);

   assign pulse_inc = (pulse_ff == '1) ? pulse_ff : pulse_ff + urpm_pkg::PULSE_W'(1);

   assign dly_full = urpm_pkg::DLY_FULL_W'(rate) *
                     urpm_pkg::DLY_FULL_W'(urpm_pkg::DELAY_US);
   assign dly_sat  = (dly_full > urpm_pkg::DLY_FULL_W'({urpm_pkg::DELAY_W{1'b1}}))
                     ? '1 : urpm_pkg::DELAY_W'(dly_full);

   assign p1_in = urpm_pkg::P1_W'(req_distance_mm) * urpm_pkg::P1_W'(urpm_pkg::ECHO_NUM)
                  + urpm_pkg::P1_W'(urpm_pkg::ECHO_RND);
   assign p2      = urpm_pkg::P2_W'(p1_ff) * urpm_pkg::P2_W'(rate);
   assign elen_in = urpm_pkg::ECHO_W'(p2 >> urpm_pkg::ECHO_SHIFT);
   assign elen_clamp = (elen_ff == '0) ? urpm_pkg::ECHO_W'(1) : elen_ff;

   assign echo_dec = (echo_cnt_ff == '0) ? '0 : echo_cnt_ff - urpm_pkg::ECHO_W'(1);

   assign status.load = prev_trig_ff && !req_trig_level &&
                        (urpm_pkg::PULSE_W'(need) <= pulse_inc);
   assign status.measuring  = measuring_ff;
   assign status.delay_zero = (delay_ff == '0);
   assign status.echo_high  = echo_ff;

   always_comb begin
      tpu_in       = csr_wr_en ? csr_wr_data : tpu_ff;
      prev_trig_in = prev_trig_ff;
      pulse_in     = pulse_ff;
      delay_in     = delay_ff;
      echo_cnt_in  = echo_cnt_ff;
      measuring_in = measuring_ff;
      echo_in      = echo_ff;

      if (cmd.capture) begin
         prev_trig_in = req_trig_level;
         if (!prev_trig_ff && req_trig_level) begin
            pulse_in = '0;
         end else if (prev_trig_ff) begin
            pulse_in = pulse_inc;
         end
      end

      if (cmd.step && measuring_ff) begin
         if (delay_ff != '0) begin
            delay_in = delay_ff - urpm_pkg::DELAY_W'(1);
            if (delay_ff == urpm_pkg::DELAY_W'(1)) echo_in = 1'b1;
         end else begin
            echo_cnt_in = echo_dec;
            if (echo_dec == '0) begin
               echo_in      = 1'b0;
               measuring_in = 1'b0;
            end
         end
      end

      // reload, then the first delay step (the delay is never zero here)
      if (cmd.load_step) begin
         measuring_in = 1'b1;
         echo_cnt_in  = elen_clamp;
         delay_in     = dly_sat - urpm_pkg::DELAY_W'(1);
         if (dly_sat == urpm_pkg::DELAY_W'(1)) echo_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff       <= urpm_pkg::TPU_W'(1);
         prev_trig_ff <= 1'b0;
         pulse_ff     <= '0;
         delay_ff     <= '0;
         echo_cnt_ff  <= '0;
         measuring_ff <= 1'b0;
         echo_ff      <= 1'b0;
      end else begin
         tpu_ff       <= tpu_in;
         prev_trig_ff <= prev_trig_in;
         pulse_ff     <= pulse_in;
         delay_ff     <= delay_in;
         echo_cnt_ff  <= echo_cnt_in;
         measuring_ff <= measuring_in;
         echo_ff      <= echo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) p1_ff <= p1_in;
      if (cmd.mul) elen_ff <= elen_in;
   end

   assign echo_level = echo_ff;

endmodule

>>> hw/rtl/ultrasonic_ranger_pulse_model.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_pulse_model: trigger/echo ranger, one tick per item
// Measures trigger pulses and plays back an echo pulse whose length follows
// the sampled target distance.
// ----------------------------------------------------------------------------
// Each accepted item is one tick of simulated time and yields exactly one
// result item: the echo level after that tick. A trigger high pulse of at
// least MIN_TRIG_US microseconds, ended by a falling edge, samples
// distance_mm, waits DELAY_US microseconds and then drives echo high for
// ((distance_mm*23814 + 2048) * ticks_per_us) >> 12 ticks (at least one).
// The item that ends a valid trigger pulse also passes through ST_MUL and
// ST_LOAD: the echo length comes from two registered multiplier steps
// (distance times the Q12 scale, then times ticks_per_us) before the
// counters reload. While a result waits in the output register with
// rsp_ready low, req_ready stays low and the next item is held off until
// the result is taken; rsp_ready reaches req_ready combinationally.
// ticks_per_us (reset 1, zero acts as 1) is written through csr_wr_en and
// csr_wr_data, by the user only while the block is idle; not enforced.
module ultrasonic_ranger_pulse_model (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_wr_en,
   input  logic [urpm_pkg::TPU_W-1:0]      csr_wr_data,
   // tick items in
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_trig_level,
   input  logic [urpm_pkg::DIST_W-1:0]     req_distance_mm,
   // echo items out
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_echo_level
);

   urpm_pkg::urpm_cmd_type    cmd;
   urpm_pkg::urpm_status_type status;

   // sequencer: accept, multiplier steps, result handshake
   urpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: counters, multiplier, rate register; echo register is the
   // result payload and holds while the result waits
   urpm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_trig_level  (req_trig_level),
      .req_distance_mm (req_distance_mm),
      .cmd             (cmd),
      .status          (status),
      .echo_level      (rsp_echo_level)
   );

   // an idle counter set has no pending delay
   a_idle_no_delay: assert property (@(posedge clock) disable iff (reset)
      !status.measuring |-> status.delay_zero)
      else $error("delay counter nonzero while not measuring");

   // echo is high only inside a measurement
   a_echo_in_measure: assert property (@(posedge clock) disable iff (reset)
      status.echo_high |-> status.measuring)
      else $error("echo high outside a measurement");

   // an item that reloads nothing gets its result on the next cycle
   a_fast_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !status.load) |=> rsp_valid)
      else $error("missing result after a single-cycle item");

   // a reloading item blocks input for its multiplier steps
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.load) |=> !req_ready)
      else $error("input taken during echo length computation");

endmodule

>>> test/ultrasonic_ranger_pulse_model_test.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_pulse_model_test: self-checking bench for the ranger
// Drives tick items through the request channel, predicts the echo level of
// every tick and compares each response item with the oldest prediction.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_pulse_model_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRECTED_ROWS = 7;

   // one row of the directed table: a run of identical tick items
   typedef struct packed {
      logic [15:0]                 count;
      logic                        trig;
      logic [urpm_pkg::DIST_W-1:0] distance;
      logic                        typed;  // echo below is known without the predictor
      logic                        echo;
   } tick_row_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_wr_en;
   logic [urpm_pkg::TPU_W-1:0]  csr_wr_data;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_trig_level;
   logic [urpm_pkg::DIST_W-1:0] req_distance_mm;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic                        rsp_echo_level;

   // predictor state: trigger edge detect, counters and echo pin
   logic [urpm_pkg::TPU_W-1:0]   tpu_setting;
   logic                         trig_was_high;
   logic [urpm_pkg::PULSE_W-1:0] width_count;
   logic [urpm_pkg::DELAY_W-1:0] holdoff_count;
   logic [urpm_pkg::ECHO_W-1:0]  echo_count;
   logic                         ranging;
   logic                         echo_now;

   logic         echo_expected [$];
   int unsigned  ticks_sent;
   int unsigned  error_count;
   bit           quiet;         // no idling on either side
   bit           hold_request;  // ask the receiver for one long hold-off
   tick_row_type directed_rows [DIRECTED_ROWS];

   ultrasonic_ranger_pulse_model i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_trig_level  (req_trig_level),
      .req_distance_mm (req_distance_mm),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_echo_level  (rsp_echo_level)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the predicted ranger by one tick and return the echo level.
   // Trigger handling comes first, then one counter step.
   task automatic step_ranger(input logic trig,
                              input logic [urpm_pkg::DIST_W-1:0] distance,
                              output logic echo);
      int unsigned       rate;
      longint unsigned   hold;
      longint unsigned   span;
      rate = (tpu_setting == '0) ? 1 : tpu_setting;
      if (!trig_was_high && trig) begin
         width_count = '0;
      end else if (trig_was_high) begin
         if (width_count != '1) width_count++;
         // falling edge after a long enough pulse: sample distance, reload
         if (!trig && width_count >= urpm_pkg::MIN_TRIG_US * rate) begin
            hold = longint'(urpm_pkg::DELAY_US) * rate;
            span = 64'(distance);
            span = ((span * urpm_pkg::ECHO_NUM + urpm_pkg::ECHO_RND) * rate)
                   >> urpm_pkg::ECHO_SHIFT;
            if (hold > 64'hFFFF) hold = 64'hFFFF;
            if (span > 64'hFF_FFFF) span = 64'hFF_FFFF;
            if (span < 1) span = 1;
            holdoff_count = hold[urpm_pkg::DELAY_W-1:0];
            echo_count    = span[urpm_pkg::ECHO_W-1:0];
            ranging       = 1'b1;
         end
      end
      trig_was_high = trig;
      if (ranging) begin
         if (holdoff_count != '0) begin
            holdoff_count--;
            if (holdoff_count == '0) echo_now = 1'b1;
         end else begin
            if (echo_count != '0) echo_count--;
            if (echo_count == '0) begin
               echo_now = 1'b0;
               ranging  = 1'b0;
            end
         end
      end
      echo = echo_now;
   endtask

   // Offer one tick item, hold it until accepted, then queue its echo level.
   // A typed row queues its own echo value; the predictor still advances.
   task automatic send_tick(input logic trig,
                            input logic [urpm_pkg::DIST_W-1:0] distance,
                            input logic typed, input logic typed_echo);
      logic echo;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_trig_level  <= trig;
      req_distance_mm <= distance;
      do @(posedge clock); while (!req_ready);
      step_ranger(trig, distance, echo);
      echo_expected.push_back(typed ? typed_echo : echo);
      ticks_sent++;
   endtask

   // Drop valid and pause until every queued echo level has come back.
   task automatic wait_for_echoes();
      req_valid <= 1'b0;
      while (echo_expected.size() != 0) @(posedge clock);
   endtask

   // Write ticks_per_us; only called with nothing in flight.
   task automatic write_rate(input logic [urpm_pkg::TPU_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tpu_setting = value;
   endtask

   // Random tick stream, mostly well-formed trigger pulses with random
   // distances, followed by either a wait for the echo or an early retrigger.
   // The rest is short bursts of trigger noise. Waits and retrigger gaps stop
   // at the end of the budget.
   task automatic run_random(input int unsigned budget);
      int unsigned                 stop_at;
      int unsigned                 need;
      int unsigned                 high_len;
      int unsigned                 waited;
      logic [urpm_pkg::DIST_W-1:0] distance;
      stop_at = ticks_sent + budget;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(0, 9) < 7) begin
            need = urpm_pkg::MIN_TRIG_US * ((tpu_setting == '0) ? 1 : tpu_setting);
            // now and then one tick short of a valid pulse
            high_len = ($urandom_range(0, 4) == 0) ? need - 1
                                                   : need + $urandom_range(0, 3);
            if ($urandom_range(0, 15) == 0)
               distance = urpm_pkg::DIST_W'($urandom_range(0, urpm_pkg::DIST_MAX));
            else distance = urpm_pkg::DIST_W'($urandom_range(0, 40));
            repeat (high_len) send_tick(1'b1, urpm_pkg::DIST_W'($urandom), 1'b0, 1'b0);
            send_tick(1'b0, distance, 1'b0, 1'b0);
            if ($urandom_range(0, 2) == 0) begin
               // retrigger after a random gap, often inside the delay or the echo
               waited = $urandom_range(1, 300);
               while (waited != 0 && ticks_sent < stop_at) begin
                  send_tick(1'b0, urpm_pkg::DIST_W'($urandom), 1'b0, 1'b0);
                  waited--;
               end
            end else begin
               waited = 0;
               while (ranging && waited < 700 && ticks_sent < stop_at) begin
                  send_tick(1'b0, urpm_pkg::DIST_W'($urandom), 1'b0, 1'b0);
                  waited++;
               end
               repeat ($urandom_range(1, 5))
                  send_tick(1'b0, urpm_pkg::DIST_W'($urandom), 1'b0, 1'b0);
            end
         end else begin
            repeat ($urandom_range(1, 8)) begin
               send_tick(1'($urandom_range(0, 1)), urpm_pkg::DIST_W'($urandom),
                         1'b0, 1'b0);
            end
         end
      end
   endtask

   // Response side: random ready with short low bursts, one long
   // hold-off on request, and ready held high through the quiet part.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (80) @(posedge clock);
            hold_request = 1'b0;
         end else if (!quiet && $urandom_range(0, 19) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare every accepted response item with the oldest queued echo level.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (echo_expected.size() == 0) begin
            error_count++;
            $display("%0t: unexpected echo item, expected none, actual %0b",
                     $time, rsp_echo_level);
         end else begin
            if (rsp_echo_level !== echo_expected[0]) begin
               error_count++;
               $display("%0t: echo_level mismatch, expected %0b, actual %0b",
                        $time, echo_expected[0], rsp_echo_level);
            end
            void'(echo_expected.pop_front());
         end
      end
   end

   // Stop a hung run.
   initial begin
      #4_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_valid       = 1'b0;
      req_trig_level  = 1'b0;
      req_distance_mm = '0;
      tpu_setting     = 8'd1;
      trig_was_high   = 1'b0;
      width_count     = '0;
      holdoff_count   = '0;
      echo_count      = '0;
      ranging         = 1'b0;
      echo_now        = 1'b0;
      ticks_sent      = 0;
      error_count     = 0;
      quiet           = 1'b0;
      hold_request    = 1'b0;

      // Directed ticks at the reset rate of one tick per microsecond:
      // idle, a ten-tick pulse at full distance that ends on distance zero
      // (shortest echo, clamped to one tick), then a nine-tick pulse and a
      // one-tick pulse that must both be ignored.
      directed_rows = '{
         '{16'd2,  1'b0, 12'd0,    1'b1, 1'b0},
         '{16'd10, 1'b1, 12'd4095, 1'b1, 1'b0},
         '{16'd1,  1'b0, 12'd0,    1'b1, 1'b0},
         '{16'd9,  1'b1, 12'd4095, 1'b0, 1'b0},
         '{16'd1,  1'b0, 12'd4095, 1'b0, 1'b0},
         '{16'd1,  1'b1, 12'd0,    1'b0, 1'b0},
         '{16'd1,  1'b0, 12'd4095, 1'b0, 1'b0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         repeat (directed_rows[i].count) begin
            send_tick(directed_rows[i].trig, directed_rows[i].distance,
                      directed_rows[i].typed, directed_rows[i].echo);
         end
      end
      wait_for_echoes();

      // Random phases over several rates; the first one also forces the
      // receiver into a long hold-off so the input side backs up.
      write_rate(8'd1);
      hold_request = 1'b1;
      run_random(450);
      wait_for_echoes();

      // zero rate behaves as one tick per microsecond
      write_rate(8'd0);
      run_random(250);
      wait_for_echoes();

      write_rate(8'd2);
      run_random(400);
      wait_for_echoes();

      write_rate(8'd3);
      run_random(400);
      wait_for_echoes();

      // Quiet part: no idling from here on.
      quiet = 1'b1;
      write_rate(8'd1);
      run_random(350);
      wait_for_echoes();

      // let any stray response show up before the verdict
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
